@@ sv/crc16d_pkg.sv @@
package crc16d_pkg;

  // Frame constants: sync pair and CRC16-MODBUS parameters.
  localparam logic [7:0]  SYNC0_BYTE = 8'hAA;
  localparam logic [7:0]  SYNC1_BYTE = 8'h55;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;

  // Result kinds.
  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_GOOD   = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  // Receive phases. The unused code is treated as hunting.
  typedef enum logic [2:0] {
    PH_SYNC0   = 3'd0,
    PH_SYNC1   = 3'd1,
    PH_LEN     = 3'd2,
    PH_TYPE    = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CRC0    = 3'd5,
    PH_CRC1    = 3'd6
  } phase_t;

  // Input request: a received byte or a timeout event.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       timeout;
  } rx_item_t;

  // Result request.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] frame_type;
    logic [7:0] data_byte;
    logic [7:0] payload_count;
  } res_item_t;

  // Byte-wide reflected CRC update, unrolled over the eight bits.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ sv/crc16_frame_deframer.sv @@
// Channel  Dir  Handshake                 Payload
// rx       in   rx_valid / rx_ready       rx_item  (rx_byte, timeout)
// res      out  res_valid / res_ready     res_item (kind, frame_type, data_byte, payload_count)
//
// Each input request is handled in the cycle it is accepted; a result, if any,
// is registered in the result register, or in the skid register behind a waiting
// result. One request per cycle is sustained while the result side keeps up. This
// two-entry output buffer parts the sides, so rx_ready drops only when both are full.
// Reset (rst, synchronous) returns the block to hunting for the first sync byte.
module crc16_frame_deframer (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   rx_valid,
  output logic                   rx_ready,
  input  crc16d_pkg::rx_item_t   rx_item,
  output logic                   res_valid,
  input  logic                   res_ready,
  output crc16d_pkg::res_item_t  res_item
);
  import crc16d_pkg::*;

  phase_t      phase, phase_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  frame_length, frame_length_next;
  logic [7:0]  type_byte, type_byte_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [7:0]  crc_low_byte, crc_low_byte_next;

  logic        has_res;
  res_item_t   res_new;
  res_item_t   skid_item;
  logic        skid_valid;
  logic        rx_fire;
  logic        res_pop;
  logic [7:0]  count_m1;
  logic [7:0]  b;

  assign rx_ready = !skid_valid;
  assign rx_fire  = rx_valid && rx_ready;
  assign res_pop  = res_valid && res_ready;
  assign b        = rx_item.rx_byte;
  assign count_m1 = frame_length - 8'd1;

  // Next frame state and the result caused by the current request.
  always_comb begin
    phase_next        = phase;
    running_crc_next  = running_crc;
    frame_length_next = frame_length;
    type_byte_next    = type_byte;
    bytes_left_next   = bytes_left;
    crc_low_byte_next = crc_low_byte;
    has_res           = 1'b0;
    res_new           = '0;
    res_new.frame_type = type_byte;
    if (rx_item.timeout) begin
      phase_next = PH_SYNC0;
      case (phase)
        PH_LEN: begin
          has_res      = 1'b1;
          res_new.kind = KIND_REJECT;
        end
        PH_TYPE, PH_PAYLOAD, PH_CRC0, PH_CRC1: begin
          has_res               = 1'b1;
          res_new.kind          = KIND_REJECT;
          res_new.payload_count = count_m1;
        end
        default: begin
        end
      endcase
    end else begin
      case (phase)
        PH_SYNC1: begin
          if (b == SYNC1_BYTE) begin
            phase_next        = PH_LEN;
            running_crc_next  = CRC_INIT;
            frame_length_next = 8'd0;
            type_byte_next    = 8'd0;
            bytes_left_next   = 8'd0;
            crc_low_byte_next = 8'd0;
          end else begin
            phase_next = PH_SYNC0;
          end
        end
        PH_LEN: begin
          frame_length_next = b;
          if (b == 8'd0) begin
            phase_next   = PH_SYNC0;
            has_res      = 1'b1;
            res_new.kind = KIND_REJECT;
          end else begin
            running_crc_next = crc_feed(running_crc, b);
            phase_next       = PH_TYPE;
          end
        end
        PH_TYPE: begin
          type_byte_next   = b;
          running_crc_next = crc_feed(running_crc, b);
          bytes_left_next  = count_m1;
          phase_next       = (count_m1 == 8'd0) ? PH_CRC0 : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          running_crc_next  = crc_feed(running_crc, b);
          bytes_left_next   = bytes_left - 8'd1;
          if (bytes_left == 8'd1) begin
            phase_next = PH_CRC0;
          end
          has_res           = 1'b1;
          res_new.kind      = KIND_DATA;
          res_new.data_byte = b;
        end
        PH_CRC0: begin
          crc_low_byte_next = b;
          phase_next        = PH_CRC1;
        end
        PH_CRC1: begin
          phase_next            = PH_SYNC0;
          has_res               = 1'b1;
          res_new.kind          = ({b, crc_low_byte} == running_crc) ? KIND_GOOD : KIND_REJECT;
          res_new.payload_count = count_m1;
        end
        default: begin
          phase_next = (b == SYNC0_BYTE) ? PH_SYNC1 : PH_SYNC0;
        end
      endcase
    end
  end

  // Frame state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SYNC0;
      running_crc  <= CRC_INIT;
      frame_length <= 8'd0;
      type_byte    <= 8'd0;
      bytes_left   <= 8'd0;
      crc_low_byte <= 8'd0;
    end else if (rx_fire) begin
      phase        <= phase_next;
      running_crc  <= running_crc_next;
      frame_length <= frame_length_next;
      type_byte    <= type_byte_next;
      bytes_left   <= bytes_left_next;
      crc_low_byte <= crc_low_byte_next;
    end
  end

  // Result register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (res_pop) begin
      if (skid_valid) begin
        res_item   <= skid_item;
        skid_valid <= 1'b0;
      end else if (rx_fire && has_res) begin
        res_item <= res_new;
      end else begin
        res_valid <= 1'b0;
      end
    end else if (rx_fire && has_res) begin
      if (!res_valid) begin
        res_item  <= res_new;
        res_valid <= 1'b1;
      end else begin
        skid_item  <= res_new;
        skid_valid <= 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  // The skid entry is only ever filled behind a waiting result.
  a_skid_behind_result: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> res_valid)
    else $error("skid entry valid without a result in the output register");

  // A timeout always returns the block to hunting.
  a_timeout_hunts: assert property (@(posedge clk) disable iff (rst)
    (rx_fire && rx_item.timeout) |=> (phase == PH_SYNC0))
    else $error("timeout did not return to hunting");

  // Payload phase always has bytes left to take.
  a_payload_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |-> (bytes_left != 8'd0))
    else $error("payload phase with no bytes left");

  // The second CRC byte always yields a frame result.
  a_crc_end_result: assert property (@(posedge clk) disable iff (rst)
    (rx_fire && !rx_item.timeout && (phase == PH_CRC1)) |=> res_valid)
    else $error("frame end produced no result");
`endif

endmodule

@@ tb/crc16_frame_deframer_checker.sv @@
`timescale 1ns / 100ps

module crc16_frame_deframer_checker (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   rx_valid,
  input  logic                   rx_ready,
  input  crc16d_pkg::rx_item_t   rx_item,
  input  logic                   res_valid,
  input  logic                   res_ready,
  input  crc16d_pkg::res_item_t  res_item,
  output int                     fail_count,
  output int                     pending,
  output int                     data_seen,
  output int                     good_seen,
  output int                     reject_seen
);

  import crc16d_pkg::*;

  // Predicted receiver state.
  phase_t      hunt_phase;
  logic [15:0] crc_acc;
  logic [7:0]  len_byte;
  logic [7:0]  type_seen;
  logic [7:0]  payload_left;
  logic [7:0]  crc_lo;

  // Results the block still owes, oldest first.
  res_item_t   owed_results[$];

  // Reflected CRC16 update, one input bit at a time from the LSB.
  function automatic logic [15:0] crc16_absorb(input logic [15:0] acc, input logic [7:0] d);
    logic [15:0] c;
    logic        fb;
    c = acc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ d[i];
      c = c >> 1;
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  // Advance the predicted state by one request and queue any result it causes.
  task automatic advance_deframer(input rx_item_t rq);
    res_item_t r;
    logic      produce;
    logic [7:0] b;
    logic [15:0] on_wire;
    r = '0;
    produce = 1'b0;
    b = rq.rx_byte;
    if (rq.timeout) begin
      // A timeout rejects a frame in progress; while hunting it only restarts the hunt.
      if (hunt_phase != PH_SYNC0 && hunt_phase != PH_SYNC1) begin
        produce = 1'b1;
        r.kind = KIND_REJECT;
        r.frame_type = type_seen;
        r.payload_count = (hunt_phase == PH_LEN) ? 8'd0 : len_byte - 8'd1;
      end
      hunt_phase = PH_SYNC0;
    end else begin
      case (hunt_phase)
        PH_SYNC1: begin
          if (b == SYNC1_BYTE) begin
            hunt_phase = PH_LEN;
            crc_acc = CRC_INIT;
            len_byte = 8'd0;
            type_seen = 8'd0;
            payload_left = 8'd0;
            crc_lo = 8'd0;
          end else begin
            hunt_phase = PH_SYNC0;
          end
        end
        PH_LEN: begin
          len_byte = b;
          if (b == 8'd0) begin
            produce = 1'b1;
            r.kind = KIND_REJECT;
            r.frame_type = type_seen;
            hunt_phase = PH_SYNC0;
          end else begin
            crc_acc = crc16_absorb(crc_acc, b);
            hunt_phase = PH_TYPE;
          end
        end
        PH_TYPE: begin
          type_seen = b;
          crc_acc = crc16_absorb(crc_acc, b);
          payload_left = len_byte - 8'd1;
          hunt_phase = (payload_left == 8'd0) ? PH_CRC0 : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          crc_acc = crc16_absorb(crc_acc, b);
          payload_left = payload_left - 8'd1;
          if (payload_left == 8'd0) begin
            hunt_phase = PH_CRC0;
          end
          produce = 1'b1;
          r.kind = KIND_DATA;
          r.frame_type = type_seen;
          r.data_byte = b;
        end
        PH_CRC0: begin
          crc_lo = b;
          hunt_phase = PH_CRC1;
        end
        PH_CRC1: begin
          // The CRC travels low byte first.
          on_wire = {b, crc_lo};
          produce = 1'b1;
          r.kind = (on_wire == crc_acc) ? KIND_GOOD : KIND_REJECT;
          r.frame_type = type_seen;
          r.payload_count = len_byte - 8'd1;
          hunt_phase = PH_SYNC0;
        end
        default: begin
          hunt_phase = (b == SYNC0_BYTE) ? PH_SYNC1 : PH_SYNC0;
        end
      endcase
    end
    if (produce) begin
      owed_results.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Compare accepted results first, since they stem from earlier requests,
  // then predict from the request accepted at the same edge.
  always @(posedge clk) begin
    res_item_t want;
    if (rst) begin
      hunt_phase = PH_SYNC0;
      crc_acc = CRC_INIT;
      len_byte = 8'd0;
      type_seen = 8'd0;
      payload_left = 8'd0;
      crc_lo = 8'd0;
      owed_results.delete();
    end else begin
      if (res_valid && res_ready) begin
        if (owed_results.size() == 0) begin
          $display("%0t: unexpected result kind %0d type %02h data %02h count %0d", $time,
                   res_item.kind, res_item.frame_type, res_item.data_byte,
                   res_item.payload_count);
          fail_count++;
        end else begin
          want = owed_results.pop_front();
          check_field("kind", int'(want.kind), int'(res_item.kind));
          check_field("frame_type", int'(want.frame_type), int'(res_item.frame_type));
          check_field("data_byte", int'(want.data_byte), int'(res_item.data_byte));
          check_field("payload_count", int'(want.payload_count),
                      int'(res_item.payload_count));
          if (want.kind == KIND_DATA) begin
            data_seen++;
          end else if (want.kind == KIND_GOOD) begin
            good_seen++;
          end else begin
            reject_seen++;
          end
        end
      end
      if (rx_valid && rx_ready) begin
        advance_deframer(rx_item);
      end
    end
    pending = owed_results.size();
  end

endmodule

@@ tb/crc16_frame_deframer_tb.sv @@
`timescale 1ns / 100ps

module crc16_frame_deframer_tb;

  import crc16d_pkg::*;

  localparam int ITEM_TARGET = 1350;
  localparam int CYCLE_LIMIT = 400000;

  // Ways a frame can be spoiled.
  localparam int FAULT_NONE = 0;
  localparam int FAULT_CRC  = 1;
  localparam int FAULT_CUT  = 2;

  // Receiver behaviors.
  localparam int RDY_ALWAYS   = 0;
  localparam int RDY_MOSTLY   = 1;
  localparam int RDY_RARELY   = 2;
  localparam int RDY_PERIODIC = 3;

  logic      clk = 1'b0;
  logic      rst;
  logic      rx_valid;
  logic      rx_ready;
  rx_item_t  rx_item;
  logic      res_valid;
  logic      res_ready = 1'b0;
  res_item_t res_item;

  int fail_count;
  int pending;
  int data_seen;
  int good_seen;
  int reject_seen;

  int cycle_cnt = 0;
  int burst_left = 0;
  int sent_cnt = 0;
  int frames_sent = 0;
  int big_left = 2;
  int rdy_mode = RDY_ALWAYS;
  int rdy_left = 0;

  crc16_frame_deframer uut (
    .clk       (clk),
    .rst       (rst),
    .rx_valid  (rx_valid),
    .rx_ready  (rx_ready),
    .rx_item   (rx_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
  );

  crc16_frame_deframer_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .rx_valid    (rx_valid),
    .rx_ready    (rx_ready),
    .rx_item     (rx_item),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_item    (res_item),
    .fail_count  (fail_count),
    .pending     (pending),
    .data_seen   (data_seen),
    .good_seen   (good_seen),
    .reject_seen (reject_seen)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("crc16_frame_deframer: mismatch");
      $finish;
    end
  end

  // The result side switches between several stall behaviors every so often.
  always @(posedge clk) begin
    if (rdy_left == 0) begin
      rdy_mode = $urandom_range(RDY_ALWAYS, RDY_PERIODIC);
      rdy_left = $urandom_range(20, 150);
    end else begin
      rdy_left--;
    end
    case (rdy_mode)
      RDY_ALWAYS:   res_ready <= 1'b1;
      RDY_MOSTLY:   res_ready <= ($urandom_range(0, 3) != 0);
      RDY_RARELY:   res_ready <= ($urandom_range(0, 3) == 0);
      default:      res_ready <= cycle_cnt[2];
    endcase
  end

  // Byte-wide MODBUS CRC used to build frames on the wire.
  function automatic logic [15:0] modbus_fold(input logic [15:0] acc, input logic [7:0] d);
    logic [15:0] c;
    c = acc ^ {8'h00, d};
    repeat (8) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Offer one request and wait for it to be taken; bursts end in random gaps.
  task automatic send_req(input logic [7:0] b, input logic to);
    int       gap;
    rx_item_t rq;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap != 0) begin
        rx_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    rq.rx_byte = b;
    rq.timeout = to;
    rx_valid <= 1'b1;
    rx_item <= rq;
    do @(posedge clk); while (!rx_ready);
    burst_left--;
    sent_cnt++;
  endtask

  // Send sync, length and, for a nonzero length, type, payload and CRC, optionally spoiled.
  task automatic send_frame(input logic [7:0] len, input logic [7:0] ftype, input int fault,
                            input bit ones);
    logic [7:0]  body[$];
    logic [15:0] crc;
    logic [7:0]  fill;
    int          keep;
    body.push_back(len);
    if (len != 8'd0) begin
      body.push_back(ftype);
      for (int i = 1; i < len; i++) begin
        fill = 8'($urandom_range(0, 255));
        body.push_back(ones ? 8'hFF : fill);
      end
      crc = CRC_INIT;
      for (int i = 0; i < body.size(); i++) begin
        crc = modbus_fold(crc, body[i]);
      end
      if (fault == FAULT_CRC) begin
        crc = crc ^ (16'h0001 << $urandom_range(0, 15));
      end
      body.push_back(crc[7:0]);
      body.push_back(crc[15:8]);
    end
    keep = (fault == FAULT_CUT) ? $urandom_range(0, body.size() - 1) : body.size();
    send_req(SYNC0_BYTE, 1'b0);
    send_req(SYNC1_BYTE, 1'b0);
    for (int i = 0; i < keep; i++) begin
      send_req(body[i], 1'b0);
    end
    if (fault == FAULT_CUT) begin
      send_req(8'($urandom_range(0, 255)), 1'b1);
    end
    frames_sent++;
  endtask

  initial begin
    int          pick;
    int          fault;
    int          n;
    logic [7:0]  len;
    logic [7:0]  b;
    rst <= 1'b1;
    rx_valid <= 1'b0;
    rx_item <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: timeout while hunting, broken sync on a repeated first byte,
    // zero length, timeout right after sync, empty payload, extreme bytes.
    send_req(8'hFF, 1'b1);
    send_req(SYNC0_BYTE, 1'b0);
    send_req(SYNC0_BYTE, 1'b0);
    send_req(SYNC1_BYTE, 1'b0);
    send_frame(8'd0, 8'h00, FAULT_NONE, 1'b0);
    send_req(SYNC0_BYTE, 1'b0);
    send_req(SYNC1_BYTE, 1'b0);
    send_req(8'h00, 1'b1);
    send_frame(8'd1, 8'hFF, FAULT_NONE, 1'b0);
    send_frame(8'd2, 8'h00, FAULT_NONE, 1'b1);

    // Random: mostly well-formed frames, mixed with spoiled frames and line noise.
    while (sent_cnt < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (big_left > 0 && $urandom_range(0, 99) < 3) begin
        len = (big_left == 2) ? 8'd255 : 8'($urandom_range(100, 254));
        big_left--;
      end else if ($urandom_range(0, 19) == 0) begin
        len = 8'd1;
      end else begin
        len = 8'($urandom_range(2, 16));
      end
      if (pick < 80) begin
        fault = (pick < 60) ? FAULT_NONE : (pick < 70) ? FAULT_CRC : FAULT_CUT;
        send_frame(len, 8'($urandom_range(0, 255)), fault, 1'b0);
      end else if (pick < 85) begin
        send_frame(8'd0, 8'h00, FAULT_NONE, 1'b0);
      end else if (pick < 92) begin
        send_req(SYNC0_BYTE, 1'b0);
        if ($urandom_range(0, 3) == 0) begin
          b = SYNC0_BYTE;
        end else begin
          do b = 8'($urandom_range(0, 255)); while (b == SYNC1_BYTE);
        end
        send_req(b, 1'b0);
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          send_req(8'($urandom_range(0, 255)), ($urandom_range(0, 4) == 0));
        end
        // A closing timeout puts the block back to hunting.
        send_req(8'($urandom_range(0, 255)), 1'b1);
      end
    end
    rx_valid <= 1'b0;

    // Let the checker take in the last request before draining.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d requests in %0d frames plus sync breaks and noise.",
             sent_cnt, frames_sent);
    $display("Checked %0d payload bytes, %0d good frames, %0d rejected frames.",
             data_seen, good_seen, reject_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("crc16_frame_deframer: match");
    end else begin
      $display("crc16_frame_deframer: mismatch");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/crc16d_pkg.sv
sv/crc16_frame_deframer.sv
tb/crc16_frame_deframer_checker.sv
tb/crc16_frame_deframer_tb.sv
